@@ hdl/psd_pkg.sv @@
package psd_pkg;

    typedef logic signed [15:0] t_coord;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord seg_a_x;
        t_coord seg_a_y;
        t_coord seg_b_x;
        t_coord seg_b_y;
    } t_in;

    typedef struct packed {
        logic [16:0] distance;
        t_coord      nearest_x;
        t_coord      nearest_y;
        logic [1:0]  nearest_kind;
    } t_out;

    localparam logic [1:0] KIND_FOOT = 2'd0;
    localparam logic [1:0] KIND_A    = 2'd1;
    localparam logic [1:0] KIND_B    = 2'd2;

    localparam logic [16:0] DIST_MAX = 17'h1FFFF;

    // squared-distance divider: 4*C^2 / L for a foot, else 4*S / 1; quotient below 2^35
    localparam int NUM_W  = 68;
    localparam int DEN_W  = 34;
    localparam int QUO_W  = 36;
    // foot divider: (2|dot*d| + L) / 2L
    localparam int FNUM_W = 52;
    localparam int FDEN_W = 35;
    localparam int FOOT_W = 17;

    typedef struct packed {
        logic [1:0] kind;
        t_coord     ax;
        t_coord     ay;
        t_coord     bx;
        t_coord     by;
    } t_geo;

    typedef struct packed {
        logic [1:0] kind;
        t_coord     nx;
        t_coord     ny;
    } t_near;

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [FNUM_W-1:0] fnum_x;
        logic [FNUM_W-1:0] fnum_y;
        logic [FDEN_W-1:0] fden;
        logic              neg_x;
        logic              neg_y;
        t_geo              geo;
    } t_front;

endpackage

@@ hdl/psd_front.sv @@
module psd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  psd_pkg::t_in    i_data,
    output logic            o_valid,
    output psd_pkg::t_front o_data
);
    import psd_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // stage 1: differences
    logic signed [16:0] r1_dx, r1_dy, r1_ux, r1_uy, r1_vx, r1_vy;
    t_coord             r1_ax, r1_ay, r1_bx, r1_by;
    logic               r1_on_a, r1_on_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx   <= 17'(i_data.seg_b_x) - 17'(i_data.seg_a_x);
            r1_dy   <= 17'(i_data.seg_b_y) - 17'(i_data.seg_a_y);
            r1_ux   <= 17'(i_data.point_x) - 17'(i_data.seg_a_x);
            r1_uy   <= 17'(i_data.point_y) - 17'(i_data.seg_a_y);
            r1_vx   <= 17'(i_data.point_x) - 17'(i_data.seg_b_x);
            r1_vy   <= 17'(i_data.point_y) - 17'(i_data.seg_b_y);
            r1_ax   <= i_data.seg_a_x;
            r1_ay   <= i_data.seg_a_y;
            r1_bx   <= i_data.seg_b_x;
            r1_by   <= i_data.seg_b_y;
            r1_on_a <= (i_data.point_x == i_data.seg_a_x) && (i_data.point_y == i_data.seg_a_y);
            r1_on_b <= (i_data.point_x == i_data.seg_b_x) && (i_data.point_y == i_data.seg_b_y);
        end
    end

    // stage 2: products
    logic signed [33:0] r2_dxdx, r2_dydy, r2_uxdx, r2_uydy, r2_uxdy, r2_uydx;
    logic signed [33:0] r2_uxux, r2_uyuy, r2_vxvx, r2_vyvy;
    logic signed [16:0] r2_dx, r2_dy;
    t_coord             r2_ax, r2_ay, r2_bx, r2_by;
    logic               r2_on_a, r2_on_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dxdx <= r1_dx * r1_dx;
            r2_dydy <= r1_dy * r1_dy;
            r2_uxdx <= r1_ux * r1_dx;
            r2_uydy <= r1_uy * r1_dy;
            r2_uxdy <= r1_ux * r1_dy;
            r2_uydx <= r1_uy * r1_dx;
            r2_uxux <= r1_ux * r1_ux;
            r2_uyuy <= r1_uy * r1_uy;
            r2_vxvx <= r1_vx * r1_vx;
            r2_vyvy <= r1_vy * r1_vy;
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_on_a <= r1_on_a;
            r2_on_b <= r1_on_b;
        end
    end

    // stage 3: sums
    logic signed [34:0] r3_l2, r3_dot, r3_cr, r3_su, r3_sv;
    logic signed [16:0] r3_dx, r3_dy;
    t_coord             r3_ax, r3_ay, r3_bx, r3_by;
    logic               r3_on_a, r3_on_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_l2   <= 35'(r2_dxdx) + 35'(r2_dydy);
            r3_dot  <= 35'(r2_uxdx) + 35'(r2_uydy);
            r3_cr   <= 35'(r2_uxdy) - 35'(r2_uydx);
            r3_su   <= 35'(r2_uxux) + 35'(r2_uyuy);
            r3_sv   <= 35'(r2_vxvx) + 35'(r2_vyvy);
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_bx   <= r2_bx;
            r3_by   <= r2_by;
            r3_on_a <= r2_on_a;
            r3_on_b <= r2_on_b;
        end
    end

    // stage 4: classify
    logic [1:0]         n4_kind;
    logic [1:0]         r4_kind;
    logic [33:0]        r4_absc, r4_l2, r4_dot, r4_s;
    logic signed [16:0] r4_dx, r4_dy;
    t_coord             r4_ax, r4_ay, r4_bx, r4_by;

    always_comb begin
        priority if (r3_l2 == '0 || r3_on_a || r3_dot < 0) begin
            n4_kind = KIND_A;
        end else if (r3_on_b || r3_dot > r3_l2) begin
            n4_kind = KIND_B;
        end else begin
            n4_kind = KIND_FOOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_kind <= n4_kind;
            r4_absc <= r3_cr[34] ? 34'(-r3_cr) : r3_cr[33:0];
            r4_l2   <= r3_l2[33:0];
            r4_dot  <= r3_dot[33:0];
            r4_s    <= (n4_kind == KIND_B) ? r3_sv[33:0] : r3_su[33:0];
            r4_dx   <= r3_dx;
            r4_dy   <= r3_dy;
            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;
            r4_bx   <= r3_bx;
            r4_by   <= r3_by;
        end
    end

    // stage 5: cross squared, projection numerators
    logic signed [34:0] dot_s;
    logic [67:0]        r5_c2;
    logic signed [51:0] r5_px, r5_py;
    logic [33:0]        r5_l2, r5_s;
    logic [1:0]         r5_kind;
    t_coord             r5_ax, r5_ay, r5_bx, r5_by;

    assign dot_s = {1'b0, r4_dot};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_c2   <= 68'(r4_absc) * 68'(r4_absc);
            r5_px   <= 52'(dot_s) * 52'(r4_dx);
            r5_py   <= 52'(dot_s) * 52'(r4_dy);
            r5_l2   <= r4_l2;
            r5_s    <= r4_s;
            r5_kind <= r4_kind;
            r5_ax   <= r4_ax;
            r5_ay   <= r4_ay;
            r5_bx   <= r4_bx;
            r5_by   <= r4_by;
        end
    end

    // stage 6: divider operands
    logic        foot;
    logic [51:0] abs_px, abs_py;

    assign foot   = (r5_kind == KIND_FOOT);
    assign abs_px = r5_px[51] ? 52'(-r5_px) : 52'(r5_px);
    assign abs_py = r5_py[51] ? 52'(-r5_py) : 52'(r5_py);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data.num     <= foot ? {r5_c2[65:0], 2'b00} : {32'd0, r5_s, 2'b00};
            o_data.den     <= foot ? r5_l2 : 34'd1;
            o_data.fnum_x  <= {abs_px[50:0], 1'b0} + 52'(r5_l2);
            o_data.fnum_y  <= {abs_py[50:0], 1'b0} + 52'(r5_l2);
            o_data.fden    <= {r5_l2, 1'b0};
            o_data.neg_x   <= r5_px[51];
            o_data.neg_y   <= r5_py[51];
            o_data.geo     <= '{kind: r5_kind, ax: r5_ax, ay: r5_ay, bx: r5_bx, by: r5_by};
        end
    end

    assign o_valid = r_v6;

endmodule

@@ hdl/psd_div.sv @@
module psd_div #(
    parameter int NW = 68,
    parameter int DW = 34,
    parameter int QW = 36,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);
    // restoring division, one quotient bit per stage; num >> QW must be below den

    logic          r_v   [QW];
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];
    logic [PW-1:0] r_pay [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] rem_in, den_in;
        logic [QW-1:0] lo_in, quo_in, quo_nx;
        logic [PW-1:0] pay_in;
        logic [DW:0]   sh;
        logic          ge;

        if (s == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = DW'(i_num[NW-1:QW]);
            assign lo_in  = i_num[QW-1:0];
            assign den_in = i_den;
            assign quo_in = '0;
            assign pay_in = i_pay;
        end else begin : g_next
            assign v_in   = r_v[s-1];
            assign rem_in = r_rem[s-1];
            assign lo_in  = r_lo[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
            assign pay_in = r_pay[s-1];
        end

        assign sh = {rem_in, lo_in[QW-1-s]};
        assign ge = sh >= {1'b0, den_in};

        always_comb begin
            quo_nx = quo_in;
            quo_nx[QW-1-s] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? DW'(sh - {1'b0, den_in}) : sh[DW-1:0];
                r_lo[s]  <= lo_in;
                r_den[s] <= den_in;
                r_quo[s] <= quo_nx;
                r_pay[s] <= pay_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_pay   = r_pay[QW-1];

endmodule

@@ hdl/psd_sqrt.sv @@
module psd_sqrt #(
    parameter int NW = 36,
    parameter int PW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [NW-1:0]   i_num,
    input  logic [PW-1:0]   i_pay,
    output logic            o_valid,
    output logic [NW/2-1:0] o_root,
    output logic [PW-1:0]   o_pay
);
    // digit-by-digit integer square root, one root bit per stage
    localparam int RW = NW / 2;

    logic          r_v    [RW];
    logic [RW:0]   r_rem  [RW];
    logic [NW-1:0] r_num  [RW];
    logic [RW-1:0] r_root [RW];
    logic [PW-1:0] r_pay  [RW];

    for (genvar s = 0; s < RW; s++) begin : g_stage
        logic          v_in;
        logic [RW:0]   rem_in;
        logic [NW-1:0] num_in;
        logic [RW-1:0] root_in;
        logic [PW-1:0] pay_in;
        logic [RW+2:0] sh, trial;
        logic          ge;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign num_in  = i_num;
            assign root_in = '0;
            assign pay_in  = i_pay;
        end else begin : g_next
            assign v_in    = r_v[s-1];
            assign rem_in  = r_rem[s-1];
            assign num_in  = r_num[s-1];
            assign root_in = r_root[s-1];
            assign pay_in  = r_pay[s-1];
        end

        assign sh    = {rem_in, num_in[2*(RW-1-s)+1 -: 2]};
        assign trial = (RW+3)'({root_in, 2'b01});
        assign ge    = sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? (RW+1)'(sh - trial) : sh[RW:0];
                r_num[s]  <= num_in;
                r_root[s] <= {root_in[RW-2:0], ge};
                r_pay[s]  <= pay_in;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_pay   = r_pay[RW-1];

endmodule

@@ hdl/point_segment_distance_core.sv @@
// Pipeline from input accept to o_valid: 6 geometry stages, 36 divider stages,
// 18 square root stages, 1 output register.
// Throughput: one item per cycle; the whole pipe advances together and holds on a stall.
// Reset: synchronous active-low i_rst_n clears all valid bits; data registers are not reset.
module point_segment_distance_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  psd_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output psd_pkg::t_out o_data
);
    import psd_pkg::*;

    logic   en;
    logic   r_out_valid;
    t_out   r_out;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    logic   front_valid;
    t_front front_data;

    psd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (front_valid),
        .o_data  (front_data)
    );

    logic             div_valid;
    logic [QUO_W-1:0] q_main, q_x, q_y;
    t_geo             div_geo;
    logic             neg_x, neg_y;

    psd_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W), .PW($bits(t_geo))) u_div_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_num   (front_data.num),
        .i_den   (front_data.den),
        .i_pay   (front_data.geo),
        .o_valid (div_valid),
        .o_quo   (q_main),
        .o_pay   (div_geo)
    );

    psd_div #(.NW(FNUM_W), .DW(FDEN_W), .QW(QUO_W), .PW(1)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_num   (front_data.fnum_x),
        .i_den   (front_data.fden),
        .i_pay   (front_data.neg_x),
        .o_valid (),
        .o_quo   (q_x),
        .o_pay   (neg_x)
    );

    psd_div #(.NW(FNUM_W), .DW(FDEN_W), .QW(QUO_W), .PW(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_num   (front_data.fnum_y),
        .i_den   (front_data.fden),
        .i_pay   (front_data.neg_y),
        .o_valid (),
        .o_quo   (q_y),
        .o_pay   (neg_y)
    );

    // nearest point: foot offsets are rounded magnitudes, sign applied here
    t_coord off_x, off_y;
    t_near  near;

    assign off_x = neg_x ? 16'(-q_x[FOOT_W-1:0]) : q_x[15:0];
    assign off_y = neg_y ? 16'(-q_y[FOOT_W-1:0]) : q_y[15:0];

    always_comb begin
        near.kind = div_geo.kind;
        unique case (div_geo.kind)
            KIND_FOOT: begin
                near.nx = div_geo.ax + off_x;
                near.ny = div_geo.ay + off_y;
            end
            KIND_B: begin
                near.nx = div_geo.bx;
                near.ny = div_geo.by;
            end
            default: begin
                near.nx = div_geo.ax;
                near.ny = div_geo.ay;
            end
        endcase
    end

    logic                 sq_valid;
    logic [QUO_W/2-1:0]   root;
    t_near                sq_near;

    psd_sqrt #(.NW(QUO_W), .PW($bits(t_near))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_num   (q_main),
        .i_pay   (near),
        .o_valid (sq_valid),
        .o_root  (root),
        .o_pay   (sq_near)
    );

    // largest r with (2r-1)^2 <= N is (isqrt(N)+1)/2
    logic [QUO_W/2:0] half_up;

    assign half_up = ((QUO_W/2+1)'(root) + 1'b1) >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.distance     <= (half_up > (QUO_W/2+1)'(DIST_MAX)) ? DIST_MAX : half_up[16:0];
            r_out.nearest_x    <= sq_near.nx;
            r_out.nearest_y    <= sq_near.ny;
            r_out.nearest_kind <= sq_near.kind;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_valid |-> !q_main[QUO_W-1])
        else $error("squared distance quotient out of range");

    a_foot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_valid && div_geo.kind == KIND_FOOT) |-> (q_x[QUO_W-1:FOOT_W] == '0
            && q_y[QUO_W-1:FOOT_W] == '0))
        else $error("foot offset out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> o_valid)
        else $error("output item lost during stall");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid not cleared by reset");

endmodule

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psd_pkg::*;

    class distance_scoreboard;
        t_out   expected_q[$];
        int     mismatches = 0;
        int     results_seen = 0;

        function automatic logic [16:0] root_of_ratio(logic [127:0] num4, logic [127:0] den);
            logic [127:0] lo, hi, mid, k;
            lo = 0;
            hi = 262144;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                k = 2 * mid - 1;
                if (k * k * den <= num4) lo = mid;
                else hi = mid - 1;
            end
            return (lo > 131071) ? DIST_MAX : lo[16:0];
        endfunction

        // nearest integer, ties away from zero
        function automatic longint round_away(longint num, longint den);
            longint q;
            q = ((num < 0 ? -num : num) * 2 + den) / (2 * den);
            return (num < 0) ? -q : q;
        endfunction

        function automatic t_out nearest_on_segment(t_in it);
            longint px, py, ax, ay, bx, by, dx, dy, ux, uy, l2, dot, cr, ex, ey;
            logic [127:0] wide_cr;
            t_out r;
            px = it.point_x;  py = it.point_y;
            ax = it.seg_a_x;  ay = it.seg_a_y;
            bx = it.seg_b_x;  by = it.seg_b_y;
            dx = bx - ax;  dy = by - ay;
            ux = px - ax;  uy = py - ay;
            l2 = dx * dx + dy * dy;
            dot = ux * dx + uy * dy;
            if (l2 == 0 || (ux == 0 && uy == 0) || dot < 0) begin
                r.distance = root_of_ratio(128'(ux * ux + uy * uy) << 2, 1);
                r.nearest_x = it.seg_a_x;
                r.nearest_y = it.seg_a_y;
                r.nearest_kind = KIND_A;
            end else if ((px == bx && py == by) || dot > l2) begin
                ex = px - bx;
                ey = py - by;
                r.distance = root_of_ratio(128'(ex * ex + ey * ey) << 2, 1);
                r.nearest_x = it.seg_b_x;
                r.nearest_y = it.seg_b_y;
                r.nearest_kind = KIND_B;
            end else begin
                cr = ux * dy - uy * dx;
                if (cr < 0) cr = -cr;
                wide_cr = 128'(cr);
                r.distance = root_of_ratio((wide_cr * wide_cr) << 2, 128'(l2));
                r.nearest_x = 16'(ax + round_away(dot * dx, l2));
                r.nearest_y = 16'(ay + round_away(dot * dy, l2));
                r.nearest_kind = KIND_FOOT;
            end
            return r;
        endfunction

        function void note_query(t_in it);
            expected_q.insert(expected_q.size(), nearest_on_segment(it));
        endfunction

        function void check_result(t_out got);
            t_out want;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %p", got);
                return;
            end
            want = expected_q.pop_front();
            if (got.distance !== want.distance || got.nearest_x !== want.nearest_x ||
                got.nearest_y !== want.nearest_y || got.nearest_kind !== want.nearest_kind) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected %p got %p", results_seen, want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic   i_clk = 0;
    logic   i_rst_n = 0;
    logic   i_valid = 0;
    logic   o_ready;
    t_in    i_data = '0;
    logic   o_valid;
    logic   i_ready = 0;
    t_out   o_data;

    distance_scoreboard sb = new();
    bit     hold_done = 0;
    bit     no_gaps = 0;

    point_segment_distance_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_query(t_in it);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (!o_ready);
        sb.note_query(it);
    endtask

    task automatic send_coords(int px, int py, int ax, int ay, int bx, int by);
        t_in it;
        it.point_x = 16'(px);  it.point_y = 16'(py);
        it.seg_a_x = 16'(ax);  it.seg_a_y = 16'(ay);
        it.seg_b_x = 16'(bx);  it.seg_b_y = 16'(by);
        send_query(it);
    endtask

    function automatic t_coord near_coord(t_coord base);
        return t_coord'(int'(base) + $signed($urandom_range(0, 400)) - 200);
    endfunction

    task automatic send_random_query();
        t_in it;
        int r;
        r = $urandom_range(0, 99);
        it = {$urandom, $urandom, $urandom};
        if (r < 45) begin
            // compact geometry: all three classes of nearest point show up often
            it.seg_a_x = near_coord(it.seg_a_x);
            it.seg_a_y = near_coord(it.seg_a_y);
            it.seg_b_x = near_coord(it.seg_a_x);
            it.seg_b_y = near_coord(it.seg_a_y);
            it.point_x = near_coord(it.seg_a_x);
            it.point_y = near_coord(it.seg_a_y);
        end else if (r < 55) begin
            it.seg_b_x = it.seg_a_x;
            it.seg_b_y = it.seg_a_y;
        end else if (r < 62) begin
            it.point_x = it.seg_a_x;
            it.point_y = it.seg_a_y;
        end else if (r < 69) begin
            it.point_x = it.seg_b_x;
            it.point_y = it.seg_b_y;
        end
        send_query(it);
    endtask

    // receiver: random stalls, one long hold-off so the pipe fills up
    initial begin
        int hold;
        int quiet;
        hold = 0;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
            if (!hold_done && sb.results_seen >= 120) begin
                hold_done = 1;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if (quiet > 0) begin
                quiet--;
                i_ready <= 1'b1;
            end else if ($urandom_range(0, 49) == 0) begin
                quiet = $urandom_range(30, 80);
                i_ready <= 1'b1;
            end else begin
                i_ready <= (pick_gap() == 0);
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_coords(-32768, -32768, -32768, -32768, -32768, -32768);
        send_coords(32767, 32767, 32767, 32767, 32767, 32767);
        send_coords(32767, 32767, -32768, -32768, -32768, -32768); // largest distance
        send_coords(-32768, 32767, 32767, -32768, 32767, -32768);
        send_coords(100, 50, 16, 16, 16, 16);                      // zero-length segment
        send_coords(16, 16, 16, 16, 160, 80);                      // on endpoint A
        send_coords(160, 80, 16, 16, 160, 80);                     // on endpoint B
        send_coords(-50, -30, 0, 0, 100, 0);                       // behind A
        send_coords(250, 30, 0, 0, 100, 0);                        // past B
        send_coords(50, 30, 0, 0, 100, 0);                         // interior
        send_coords(0, 16, 0, 0, 16, 0);                           // foot exactly at A
        send_coords(16, 16, 0, 0, 16, 0);                          // foot exactly at B
        send_coords(7, -11, -3, 5, 13, -9);                        // rounding of the foot
        send_coords(-7, 11, 3, -5, -13, 9);
        send_coords(32767, -32768, -32768, 32767, 32767, 32767);
        send_coords(0, 32767, -32768, -32768, 32767, -32768);
        send_coords(-32768, 0, 32767, 32767, 32767, -32768);
        send_coords(1, 1, 0, 0, 3, 1);
        send_coords(-32768, -32768, 32767, 32767, -32767, -32767);
        send_coords(32767, 0, 0, 0, 0, 0);

        for (int n = 0; n < 450; n++) begin
            if (n % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            if (n == 300) begin
                // drain completely before going on
                i_valid <= 1'b0;
                while (sb.pending() > 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            send_random_query();
        end
        i_valid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/psd_pkg.sv
hdl/psd_front.sv
hdl/psd_div.sv
hdl/psd_sqrt.sv
hdl/point_segment_distance_core.sv
verif/tb.sv
